// ===== src/mseg_pkg.sv =====
// Shared types and fixed field widths for the multi-stage envelope generator.
// Depends on nothing; imported by the core module.
`default_nettype none

package mseg_pkg;

    // Fixed widths of the command and result fields.
    localparam int FUNC_W   = 2;
    localparam int VOICE_W  = 5;
    localparam int SEL_W    = 3;
    localparam int RATE_W   = 30;
    localparam int STATUS_W = 2;

    // Stage counter holds up to eight stages plus the run-out position.
    localparam int STAGE_W  = 4;

    // Last stage that still moves freely while a note is held in envelope mode.
    localparam logic [STAGE_W-1:0] SUSTAIN_STAGE = 4'd2;

    // Command codes carried on tuser.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK = 2'd0,
        FUNC_SET  = 2'd1,
        FUNC_LOAD = 2'd2,
        FUNC_NOP  = 2'd3
    } t_func;

    // Voice status codes.
    localparam logic [STATUS_W-1:0] ST_FREE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_HELD     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RELEASED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DYING    = 2'd3;

endpackage

`default_nettype wire

// ===== src/multi_stage_envelope_generator_core.sv =====
// Multi-stage envelope generator core: per-voice state memory, per-voice stage
// table memory and the sequencer that ticks, sets, loads and advances voices.
// Depends on mseg_pkg.
//
// Usage:
//   Commands arrive on the slave stream. tuser carries the command code
//   (tick, set and advance, load stage entry, no operation); tdata carries
//   voice, stage select, level, rate, status and envelope mode. Every command
//   produces exactly one result transfer on the master stream with the
//   addressed voice's level, stage, status, run-out flag and moving flag.
//   A voice index at or above NUM_VOICES changes nothing and returns zeros.
//   A tick that does not reach its target, a load and a no-operation go from
//   execution straight to write-back. A set or a completing tick first walks
//   the stage table: each entry read is a registered read followed by its
//   compare, until an entry sets a new target; a walk that ends by freezing
//   or running out ends in a last stage check. At most NUM_STAGES entries
//   are read. One command at a time: the next is taken once the sequencer
//   is back in idle after the result is registered.
//   Reset clears the sequencer, the result valid flag and the per-voice valid
//   bits, so every voice reads as zero until first written. The stage table
//   has no reset and must be loaded before a voice walks through it.
//   While the receiver stalls, a new command is still taken; it finishes its
//   work and then holds until the receiver takes the older result.
`default_nettype none

module multi_stage_envelope_generator_core #(
    parameter int NUM_VOICES = 32,
    parameter int NUM_STAGES = 6,
    parameter int LEVEL_BITS = 30
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // Command stream.
    input  wire logic                                   i_s_axis_tvalid,
    output logic                                        o_s_axis_tready,
    // tdata, low bit up: voice(5), stage_sel(3), level_in(LEVEL_BITS),
    // rate_in(30), status_in(2), envelope_mode(1), zero fill to bytes.
    input  wire logic [((LEVEL_BITS+41+7)/8)*8-1:0]     i_s_axis_tdata,
    // tuser: func(2).
    input  wire logic [mseg_pkg::FUNC_W-1:0]            i_s_axis_tuser,
    // Result stream.
    output logic                                        o_m_axis_tvalid,
    input  wire logic                                   i_m_axis_tready,
    // tdata, low bit up: level(LEVEL_BITS), stage_out(3), status_out(2),
    // ran_out(1), moving(1), zero fill to bytes.
    output logic [((LEVEL_BITS+7+7)/8)*8-1:0]           o_m_axis_tdata
);

    import mseg_pkg::*;

    localparam int OUT_W  = ((LEVEL_BITS + 7 + 7) / 8) * 8;
    localparam int MAX_W  = (LEVEL_BITS > RATE_W) ? LEVEL_BITS : RATE_W;
    localparam int STEP_W = MAX_W + 1;
    localparam int SUM_W  = MAX_W + 2;
    localparam int VIW    = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int TDEPTH = NUM_VOICES * NUM_STAGES;
    localparam int TAW    = $clog2(TDEPTH);
    localparam int TDW    = LEVEL_BITS + RATE_W;

    localparam logic [STAGE_W-1:0] LAST_STAGE = STAGE_W'(NUM_STAGES - 1);
    localparam logic [STAGE_W-1:0] STAGE_CNT  = STAGE_W'(NUM_STAGES);

    // Input field offsets inside tdata.
    localparam int OFS_SEL  = VOICE_W;
    localparam int OFS_LVL  = OFS_SEL + SEL_W;
    localparam int OFS_RATE = OFS_LVL + LEVEL_BITS;
    localparam int OFS_ST   = OFS_RATE + RATE_W;
    localparam int OFS_MODE = OFS_ST + STATUS_W;

    typedef struct packed {
        logic [STAGE_W-1:0]       stage;
        logic [LEVEL_BITS-1:0]    level;
        logic [LEVEL_BITS-1:0]    target;
        logic signed [STEP_W-1:0] step;
        logic [STATUS_W-1:0]      status;
        logic                     mode;
    } t_voice;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ADV_CHK,
        S_ADV_EV,
        S_WB
    } t_state;

    t_state r_state;

    // Captured command.
    t_func                 r_func;
    logic [SEL_W-1:0]      r_sel;
    logic [LEVEL_BITS-1:0] r_lvl_in;
    logic [RATE_W-1:0]     r_rate_in;
    logic [STATUS_W-1:0]   r_st_in;
    logic                  r_mode_in;
    logic [VIW-1:0]        r_vidx;
    logic                  r_vok;
    logic [TAW-1:0]        r_base;

    // Working copy of the addressed voice.
    t_voice                r_work;
    logic                  r_ran;
    logic                  r_past_sus;

    // Voice state memory with per-entry valid bits.
    t_voice                r_vmem [NUM_VOICES];
    logic [NUM_VOICES-1:0] r_vvalid;
    t_voice                r_vq;
    logic                  r_vq_ok;

    // Stage table memory.
    logic [TDW-1:0]        r_tbl [TDEPTH];
    logic [TDW-1:0]        r_tbl_q;

    // Result register.
    logic                  r_ovalid;
    logic [OUT_W-1:0]      r_odata;

    // Combinational helpers.
    logic                  w_in_xfer;
    logic                  w_out_free;
    logic [VIW-1:0]        w_in_vidx;
    logic                  w_in_vok;
    t_voice                w_cur;
    logic signed [SUM_W-1:0] w_lvl_ext;
    logic signed [SUM_W-1:0] w_stp_ext;
    logic signed [SUM_W-1:0] w_tgt_ext;
    logic signed [SUM_W-1:0] w_sum;
    logic                  w_step_neg;
    logic                  w_step_pos;
    logic                  w_reach;
    logic                  w_tbl_we;
    logic [TAW-1:0]        w_tbl_waddr;
    logic [TAW-1:0]        w_tbl_raddr;
    logic [LEVEL_BITS-1:0] w_tbl_tgt;
    logic [STEP_W-1:0]     w_tbl_rate;
    logic                  w_skip;
    logic [OUT_W-1:0]      w_odata;

    // Handshake.
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_xfer       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_ovalid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    assign w_in_vidx = VIW'(i_s_axis_tdata[VOICE_W-1:0]);
    assign w_in_vok  = (32'(i_s_axis_tdata[VOICE_W-1:0]) < 32'(NUM_VOICES));

    // Voice read data; an entry never written reads as zero.
    assign w_cur = r_vq_ok ? r_vq : '0;

    // Tick arithmetic: level plus signed step against the target.
    assign w_lvl_ext  = signed'({{(SUM_W-LEVEL_BITS){1'b0}}, w_cur.level});
    assign w_tgt_ext  = signed'({{(SUM_W-LEVEL_BITS){1'b0}}, w_cur.target});
    assign w_stp_ext  = signed'({{(SUM_W-STEP_W){w_cur.step[STEP_W-1]}}, w_cur.step});
    assign w_sum      = w_lvl_ext + w_stp_ext;
    assign w_step_neg = w_cur.step[STEP_W-1];
    assign w_step_pos = !w_cur.step[STEP_W-1] && (w_cur.step != '0);
    assign w_reach    = (w_step_neg && (w_sum <= w_tgt_ext)) ||
                        (w_step_pos && (w_sum >= w_tgt_ext));

    // Stage table access.
    assign w_tbl_we    = (r_state == S_EXEC) && r_vok && (r_func == FUNC_LOAD) &&
                         (STAGE_W'(r_sel) < STAGE_CNT);
    assign w_tbl_waddr = r_base + TAW'(r_sel);
    assign w_tbl_raddr = r_base + TAW'(r_work.stage);
    assign w_tbl_tgt   = r_tbl_q[TDW-1:RATE_W];
    assign w_tbl_rate  = STEP_W'(r_tbl_q[RATE_W-1:0]);
    assign w_skip      = (r_work.level == w_tbl_tgt) ||
                         (r_past_sus && (r_work.level < w_tbl_tgt));

    // Result fields; an out-of-range voice reports zeros.
    always_comb begin
        w_odata = '0;
        if (r_vok) begin
            w_odata[LEVEL_BITS-1:0]               = r_work.level;
            w_odata[LEVEL_BITS +: 3]              = r_work.stage[2:0];
            w_odata[LEVEL_BITS+3 +: STATUS_W]     = r_work.status;
            w_odata[LEVEL_BITS+5]                 = r_ran;
            w_odata[LEVEL_BITS+6]                 = (r_work.step != '0);
        end
    end

    // Stage table memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_tbl_we) begin
            r_tbl[w_tbl_waddr] <= {r_lvl_in, r_rate_in};
        end
        r_tbl_q <= r_tbl[w_tbl_raddr];
    end

    // Voice state memory; read at the incoming voice while idle, written back
    // when a command completes.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_vq <= r_vmem[w_in_vidx];
        end
        if ((r_state == S_WB) && w_out_free && r_vok) begin
            r_vmem[r_vidx] <= r_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vvalid <= '0;
            r_vq_ok  <= 1'b0;
        end else begin
            if (r_state == S_IDLE) begin
                r_vq_ok <= r_vvalid[w_in_vidx];
            end
            if ((r_state == S_WB) && w_out_free && r_vok) begin
                r_vvalid[r_vidx] <= 1'b1;
            end
        end
    end

    // Sequencer and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_func    <= t_func'(i_s_axis_tuser);
                        r_sel     <= i_s_axis_tdata[OFS_SEL +: SEL_W];
                        r_lvl_in  <= i_s_axis_tdata[OFS_LVL +: LEVEL_BITS];
                        r_rate_in <= i_s_axis_tdata[OFS_RATE +: RATE_W];
                        r_st_in   <= i_s_axis_tdata[OFS_ST +: STATUS_W];
                        r_mode_in <= i_s_axis_tdata[OFS_MODE];
                        r_vidx    <= w_in_vidx;
                        r_vok     <= w_in_vok;
                        r_base    <= TAW'(32'(w_in_vidx) * NUM_STAGES);
                        r_state   <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_work <= w_cur;
                    r_ran  <= 1'b0;
                    r_state <= S_WB;
                    if (r_vok) begin
                        case (r_func)
                            FUNC_TICK: begin
                                if (w_reach) begin
                                    r_work.level <= w_cur.target;
                                    r_state      <= S_ADV_CHK;
                                end else if (w_step_neg || w_step_pos) begin
                                    r_work.level <= w_sum[LEVEL_BITS-1:0];
                                end
                            end
                            FUNC_SET: begin
                                r_work.stage  <= STAGE_W'(r_sel);
                                r_work.level  <= r_lvl_in;
                                r_work.status <= r_st_in;
                                r_work.mode   <= r_mode_in;
                                r_state       <= S_ADV_CHK;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_ADV_CHK: begin
                    if (r_work.stage > LAST_STAGE) begin
                        // Past the last stage: free the voice.
                        r_ran         <= (r_work.status != ST_DYING);
                        r_work.status <= ST_FREE;
                        r_state       <= S_WB;
                    end else if (r_work.mode && (r_work.status == ST_HELD) &&
                                 (r_work.stage > SUSTAIN_STAGE)) begin
                        // Held note in envelope mode stops at sustain.
                        r_work.step <= '0;
                        r_state     <= S_WB;
                    end else begin
                        // Table read of the old stage is under way.
                        r_past_sus   <= (r_work.stage > SUSTAIN_STAGE);
                        r_work.stage <= r_work.stage + STAGE_W'(1);
                        r_state      <= S_ADV_EV;
                    end
                end
                S_ADV_EV: begin
                    if (w_skip) begin
                        r_state <= S_ADV_CHK;
                    end else begin
                        r_work.target <= w_tbl_tgt;
                        r_work.step   <= (w_tbl_tgt < r_work.level) ?
                                         -signed'(w_tbl_rate) : signed'(w_tbl_rate);
                        r_state       <= S_WB;
                    end
                end
                S_WB: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= w_odata;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for the multi-stage envelope generator core, checked against an inline voice model.
// Depends on mseg_pkg and multi_stage_envelope_generator_core; needs no other files.

module testbench;
    import mseg_pkg::*;

    localparam int NUM_VOICES = 32;
    localparam int NUM_STAGES = 6;
    localparam int LEVEL_BITS = 30;
    localparam int LAST_STAGE = NUM_STAGES - 1;
    localparam int S_W = ((LEVEL_BITS + 41 + 7) / 8) * 8;
    localparam int M_W = ((LEVEL_BITS + 7 + 7) / 8) * 8;
    localparam bit [LEVEL_BITS-1:0] LEVEL_MAX = {LEVEL_BITS{1'b1}};

    // Command word layout, low bit up.
    localparam int VOICE_LSB  = 0;
    localparam int SEL_LSB    = VOICE_LSB + VOICE_W;
    localparam int LEVEL_LSB  = SEL_LSB + SEL_W;
    localparam int RATE_LSB   = LEVEL_LSB + LEVEL_BITS;
    localparam int STATUS_LSB = RATE_LSB + RATE_W;
    localparam int MODE_LSB   = STATUS_LSB + STATUS_W;

    // Result word layout, low bit up.
    localparam int R_STAGE_LSB  = LEVEL_BITS;
    localparam int R_STATUS_LSB = R_STAGE_LSB + 3;
    localparam int R_RAN_LSB    = R_STATUS_LSB + STATUS_W;
    localparam int R_MOVING_LSB = R_RAN_LSB + 1;

    localparam int ITEM_GOAL   = 1600;
    localparam int CALM_FROM   = 1400;
    localparam int DRAIN_LIMIT = 5000;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        bit [LEVEL_BITS-1:0] level;
        bit [2:0]            stage;
        bit [STATUS_W-1:0]   status;
        bit                  ran_out;
        bit                  moving;
    } t_env_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    // tdata, low bit up: voice, stage_sel, level_in, rate_in, status_in, envelope_mode.
    logic [S_W-1:0]         i_s_axis_tdata = '0;
    // tuser: func.
    logic [FUNC_W-1:0]      i_s_axis_tuser = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    // tdata, low bit up: level, stage_out, status_out, ran_out, moving.
    logic [M_W-1:0]         o_m_axis_tdata;

    // Voice model state; two-state types start at zero like the block after reset.
    bit [2:0]              env_stage  [NUM_VOICES];
    bit [LEVEL_BITS-1:0]   env_level  [NUM_VOICES];
    bit [LEVEL_BITS-1:0]   env_target [NUM_VOICES];
    bit signed [30:0]      env_step   [NUM_VOICES];
    bit [STATUS_W-1:0]     env_status [NUM_VOICES];
    bit                    env_mode   [NUM_VOICES];
    bit [LEVEL_BITS-1:0]   tbl_target  [NUM_VOICES][NUM_STAGES];
    bit [RATE_W-1:0]       tbl_rate    [NUM_VOICES][NUM_STAGES];
    bit                    tbl_written [NUM_VOICES][NUM_STAGES];

    t_env_result pending_envelopes[$];
    int          bad_results = 0;
    int          results_seen = 0;
    int          work_items = 0;
    bit          calm = 1'b0;
    int          stall_left = 0;

    multi_stage_envelope_generator_core #(
        .NUM_VOICES(NUM_VOICES),
        .NUM_STAGES(NUM_STAGES),
        .LEVEL_BITS(LEVEL_BITS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    // Walk the stage table from the voice's current stage until a stage sets a new target,
    // the voice freezes at sustain, or the envelope runs out. Returns the run-out flag.
    function automatic bit advance_voice(input int v);
        int guard;
        int stg;
        bit dying;
        bit [LEVEL_BITS-1:0] tgt;
        for (guard = 0; guard < NUM_STAGES + 2; guard++) begin
            stg = env_stage[v];
            if (stg > LAST_STAGE) begin
                dying = (env_status[v] == ST_DYING);
                env_status[v] = ST_FREE;
                return !dying;
            end
            if (env_mode[v] && env_status[v] == ST_HELD && stg > SUSTAIN_STAGE) begin
                env_step[v] = '0;
                return 1'b0;
            end
            env_stage[v] = 3'(stg + 1);
            tgt = tbl_target[v][stg];
            if (env_level[v] == tgt || (stg > SUSTAIN_STAGE && env_level[v] < tgt))
                continue;
            env_target[v] = tgt;
            if (tgt < env_level[v])
                env_step[v] = -$signed({1'b0, tbl_rate[v][stg]});
            else
                env_step[v] = $signed({1'b0, tbl_rate[v][stg]});
            return 1'b0;
        end
        return 1'b0;
    endfunction

    // One tick: move by the signed step and clamp to the target once it is met or passed.
    function automatic bit tick_voice(input int v);
        longint inc;
        longint lv;
        longint tgt;
        inc = env_step[v];
        tgt = env_target[v];
        if (inc == 0)
            return 1'b0;
        lv = env_level[v];
        lv = lv + inc;
        if ((inc < 0 && lv <= tgt) || (inc > 0 && lv >= tgt)) begin
            env_level[v] = env_target[v];
            return advance_voice(v);
        end
        env_level[v] = lv[LEVEL_BITS-1:0];
        return 1'b0;
    endfunction

    // Apply one command to the voice model and return the result the block should send.
    function automatic t_env_result predict_envelope(input t_func f, input int v, input int sel,
                                                     input bit [LEVEL_BITS-1:0] lvl,
                                                     input bit [RATE_W-1:0] rate,
                                                     input bit [STATUS_W-1:0] st,
                                                     input bit mode);
        t_env_result r;
        bit ran;
        ran = 1'b0;
        case (f)
            FUNC_TICK: ran = tick_voice(v);
            FUNC_SET: begin
                env_stage[v]  = 3'(sel);
                env_level[v]  = lvl;
                env_status[v] = st;
                env_mode[v]   = mode;
                ran = advance_voice(v);
            end
            FUNC_LOAD: begin
                if (sel < NUM_STAGES) begin
                    tbl_target[v][sel]  = lvl;
                    tbl_rate[v][sel]    = rate;
                    tbl_written[v][sel] = 1'b1;
                end
            end
            default: ;
        endcase
        r.level   = env_level[v];
        r.stage   = env_stage[v];
        r.status  = env_status[v];
        r.ran_out = ran;
        r.moving  = (env_step[v] != 0);
        return r;
    endfunction

    // Compare one result transfer with the oldest waiting expectation.
    task automatic compare_envelope_result(input logic [M_W-1:0] data);
        t_env_result got;
        t_env_result want;
        bit bad;
        got.level   = data[LEVEL_BITS-1:0];
        got.stage   = data[R_STAGE_LSB +: 3];
        got.status  = data[R_STATUS_LSB +: STATUS_W];
        got.ran_out = data[R_RAN_LSB];
        got.moving  = data[R_MOVING_LSB];
        results_seen++;
        if (pending_envelopes.size() == 0) begin
            bad_results++;
            if (bad_results <= REPORT_MAX)
                $display("result %0d arrived with nothing expected: level %h stage %0d",
                         results_seen, got.level, got.stage);
        end else begin
            want = pending_envelopes.pop_front();
            bad = (got.level != want.level) || (got.stage != want.stage) ||
                  (got.status != want.status) || (got.ran_out != want.ran_out) ||
                  (got.moving != want.moving);
            if (bad) begin
                bad_results++;
                if (bad_results <= REPORT_MAX)
                    $display({"result %0d: expected level %h stage %0d status %0d ran_out %b ",
                              "moving %b, got level %h stage %0d status %0d ran_out %b moving %b"},
                             results_seen, want.level, want.stage, want.status, want.ran_out,
                             want.moving, got.level, got.stage, got.status, got.ran_out,
                             got.moving);
            end
        end
    endtask

    // Result side: check every transfer and stall tready in random bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready)
                compare_envelope_result(o_m_axis_tdata);
            if (stall_left != 0) begin
                stall_left <= stall_left - 1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                i_m_axis_tready <= 1'b0;
                stall_left <= $urandom_range(0, 7);
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // Send one command and wait for its transfer. Called right after a rising edge;
    // tvalid is lowered only when a gap follows, so it never drops and rises in one step.
    task automatic send_cmd(input t_func f, input bit [VOICE_W-1:0] v, input bit [SEL_W-1:0] sel,
                            input bit [LEVEL_BITS-1:0] lvl, input bit [RATE_W-1:0] rate,
                            input bit [STATUS_W-1:0] st, input bit mode);
        logic [S_W-1:0] word;
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 8);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        word = '0;
        word[VOICE_LSB +: VOICE_W]   = v;
        word[SEL_LSB +: SEL_W]       = sel;
        word[LEVEL_LSB +: LEVEL_BITS] = lvl;
        word[RATE_LSB +: RATE_W]     = rate;
        word[STATUS_LSB +: STATUS_W] = st;
        word[MODE_LSB]               = mode;
        pending_envelopes.push_back(predict_envelope(f, v, sel, lvl, rate, st, mode));
        if (!(f == FUNC_NOP || (f == FUNC_LOAD && sel >= NUM_STAGES)))
            work_items++;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= word;
        i_s_axis_tuser  <= f;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    // Random level with the extremes weighted up.
    function automatic bit [LEVEL_BITS-1:0] pick_level();
        bit [31:0] raw;
        int r;
        raw = $urandom;
        r = $urandom_range(0, 9);
        if (r < 2)
            return '0;
        else if (r == 2)
            return LEVEL_MAX;
        return raw[LEVEL_BITS-1:0];
    endfunction

    // Random rate: mostly large so that stages finish within a few ticks.
    function automatic bit [RATE_W-1:0] pick_rate();
        bit [31:0] raw;
        int r;
        raw = $urandom;
        r = $urandom_range(0, 19);
        if (r < 2)
            return '0;
        else if (r < 6)
            return {RATE_W{1'b1}};
        else if (r < 15)
            raw = $urandom_range(32'h3FFF_FFFF, 32'h0800_0000);
        return raw[RATE_W-1:0];
    endfunction

    // Load one table entry; sometimes repeat the previous stage's target so that it gets skipped.
    task automatic load_stage(input bit [VOICE_W-1:0] v, input int s);
        bit [LEVEL_BITS-1:0] tgt;
        tgt = pick_level();
        if (s > 0 && tbl_written[v][s-1] && $urandom_range(0, 3) == 0)
            tgt = tbl_target[v][s-1];
        send_cmd(FUNC_LOAD, v, SEL_W'(s), tgt, pick_rate(), $urandom, $urandom);
    endtask

    // Fill every table entry of a voice that was never loaded, so its walk reads only known data.
    task automatic prime_voice(input bit [VOICE_W-1:0] v);
        int s;
        for (s = 0; s < NUM_STAGES; s++)
            if (!tbl_written[v][s])
                load_stage(v, s);
    endtask

    // Commands outside the current test: no-op, load past the table (dropped), stray tick on a random voice.
    task automatic send_noise();
        int r;
        r = $urandom_range(0, 2);
        if (r == 0)
            send_cmd(FUNC_NOP, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        else if (r == 1)
            send_cmd(FUNC_LOAD, $urandom, SEL_W'($urandom_range(NUM_STAGES, 7)), $urandom,
                     $urandom, $urandom, $urandom);
        else
            send_cmd(FUNC_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    // Tick one voice a number of times with the odd unrelated command in between.
    task automatic run_ticks(input bit [VOICE_W-1:0] v, input int count);
        int k;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(0, 9) == 0)
                send_noise();
            send_cmd(FUNC_TICK, v, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    // A voice that was never set has no step: ticks and no-ops only report zeros.
    task automatic test_idle_voices();
        send_cmd(FUNC_NOP, 5'd0, 3'd0, '0, '0, ST_FREE, 1'b0);
        send_cmd(FUNC_TICK, 5'd31, 3'd7, LEVEL_MAX, {RATE_W{1'b1}}, ST_DYING, 1'b1);
        send_cmd(FUNC_NOP, 5'd31, 3'd7, LEVEL_MAX, {RATE_W{1'b1}}, ST_DYING, 1'b1);
    endtask

    // Table for voice 0: full attack, decay, a sustain equal to the decay target, a release
    // to zero, a stage above the released level and a last stage already met.
    task automatic test_stage_table();
        send_cmd(FUNC_LOAD, 5'd0, 3'd0, LEVEL_MAX, {RATE_W{1'b1}}, ST_FREE, 1'b0);
        send_cmd(FUNC_LOAD, 5'd0, 3'd1, 30'h2000_0000, 30'h1000_0000, ST_FREE, 1'b0);
        send_cmd(FUNC_LOAD, 5'd0, 3'd2, 30'h2000_0000, 30'd1, ST_FREE, 1'b0);
        send_cmd(FUNC_LOAD, 5'd0, 3'd3, '0, {RATE_W{1'b1}}, ST_FREE, 1'b0);
        send_cmd(FUNC_LOAD, 5'd0, 3'd4, 30'h155, 30'd5, ST_FREE, 1'b0);
        send_cmd(FUNC_LOAD, 5'd0, 3'd5, '0, '0, ST_FREE, 1'b0);
        // Loads past the last stage are dropped.
        send_cmd(FUNC_LOAD, 5'd0, 3'd6, LEVEL_MAX, {RATE_W{1'b1}}, ST_DYING, 1'b1);
        send_cmd(FUNC_LOAD, 5'd0, 3'd7, LEVEL_MAX, {RATE_W{1'b1}}, ST_DYING, 1'b1);
    endtask

    // Held note in envelope mode: attack, decay, skip the equal sustain, then freeze.
    task automatic test_sustain_freeze();
        send_cmd(FUNC_SET, 5'd0, 3'd0, '0, '0, ST_HELD, 1'b1);
        run_ticks(5'd0, 4);
    endtask

    // Released note: fall to zero, skip the stages already met and run out, then a tick
    // on the freed voice still carrying a step runs out again.
    task automatic test_release_runout();
        send_cmd(FUNC_SET, 5'd0, 3'd3, 30'h2000_0000, '0, ST_RELEASED, 1'b1);
        run_ticks(5'd0, 2);
    endtask

    // Dying voices stop silently; a set past the last stage runs out at once.
    task automatic test_dying_and_stage_overflow();
        send_cmd(FUNC_SET, 5'd0, 3'd3, 30'h2000_0000, '0, ST_DYING, 1'b0);
        run_ticks(5'd0, 1);
        send_cmd(FUNC_SET, 5'd0, 3'd7, LEVEL_MAX, '0, ST_HELD, 1'b0);
        send_cmd(FUNC_SET, 5'd0, 3'd6, '0, '0, ST_DYING, 1'b0);
    endtask

    // Random traffic: mostly whole envelopes with random tables, releases from the current
    // position, control-period tick sweeps, and a little noise.
    task automatic test_random_envelopes();
        int kind;
        int k;
        int n;
        bit [VOICE_W-1:0] v;
        bit [SEL_W-1:0] sel;
        bit [STATUS_W-1:0] st;
        while (work_items < ITEM_GOAL) begin
            calm = (work_items >= CALM_FROM) || ($urandom_range(0, 4) == 0);
            kind = $urandom_range(0, 19);
            v = VOICE_W'($urandom_range(0, NUM_VOICES - 1));
            if (kind < 11) begin
                prime_voice(v);
                n = $urandom_range(0, 2);
                for (k = 0; k < n; k++)
                    load_stage(v, $urandom_range(0, NUM_STAGES - 1));
                sel = ($urandom_range(0, 9) < 7) ? 3'd0 : 3'($urandom_range(0, 7));
                n = $urandom_range(0, 9);
                if (n < 5)
                    st = ST_HELD;
                else if (n < 7)
                    st = ST_RELEASED;
                else if (n < 8)
                    st = ST_DYING;
                else
                    st = ST_FREE;
                send_cmd(FUNC_SET, v, sel, pick_level(), $urandom, st, $urandom);
                run_ticks(v, $urandom_range(1, 14));
            end else if (kind < 15) begin
                prime_voice(v);
                n = $urandom_range(0, 19);
                if (n < 12)
                    st = ST_RELEASED;
                else if (n < 17)
                    st = ST_DYING;
                else
                    st = ST_HELD;
                send_cmd(FUNC_SET, v, env_stage[v], env_level[v], $urandom, st, env_mode[v]);
                run_ticks(v, $urandom_range(1, 12));
            end else if (kind < 18) begin
                n = $urandom_range(2, 16);
                for (k = 0; k < n; k++)
                    send_cmd(FUNC_TICK, VOICE_W'(v + k), $urandom, $urandom, $urandom,
                             $urandom, $urandom);
            end else begin
                n = $urandom_range(2, 4);
                for (k = 0; k < n; k++)
                    send_noise();
            end
        end
    endtask

    initial begin
        int wait_cycles;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_idle_voices();
        test_stage_table();
        test_sustain_freeze();
        test_release_runout();
        test_dying_and_stage_overflow();
        test_random_envelopes();
        // Drain: wait for every result, then keep watching for anything unexpected.
        calm = 1'b1;
        i_s_axis_tvalid <= 1'b0;
        wait_cycles = 0;
        while (pending_envelopes.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (40) @(posedge i_clk);
        bad_results += pending_envelopes.size();
        if (bad_results == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Hard stop in case the block hangs.
    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== multi_stage_envelope_generator_core.f =====
src/mseg_pkg.sv
src/multi_stage_envelope_generator_core.sv
bench/testbench.sv
